### rtl/gtr_pkg.sv
// Shared types and constants for the glyph text renderer.
// No dependencies; used by gtr_font and glyph_text_renderer_core.
`timescale 1ns / 1ps

package gtr_pkg;

    // Screen coordinates
    localparam int COORD_W = 12;
    typedef logic [COORD_W-1:0] coord_t;
    localparam coord_t COORD_MAX = 12'hFFF;

    // Command codes carried by an input item
    typedef enum logic [1:0] {
        CMD_SET_WIDTH = 2'd0,
        CMD_WRITE_COL = 2'd1,
        CMD_DRAW      = 2'd2,
        CMD_HOME      = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_SCREEN_WIDTH  = 3'd0;
    localparam cfg_idx_t REG_SCREEN_HEIGHT = 3'd1;
    localparam cfg_idx_t REG_LEFT_MARGIN   = 3'd2;
    localparam cfg_idx_t REG_TOP_MARGIN    = 3'd3;
    localparam cfg_idx_t REG_LINE_STEP     = 3'd4;
    localparam cfg_idx_t REG_CHAR_GAP      = 3'd5;

    // Reset values of the configuration registers
    localparam coord_t     SCREEN_WIDTH_RST  = 12'd800;
    localparam coord_t     SCREEN_HEIGHT_RST = 12'd100;
    localparam coord_t     LEFT_MARGIN_RST   = 12'd10;
    localparam coord_t     TOP_MARGIN_RST    = 12'd10;
    localparam logic [7:0] LINE_STEP_RST     = 8'd20;
    localparam logic [7:0] CHAR_GAP_RST      = 8'd2;

    // Draw sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MASK,
        ST_EMIT
    } state_t;

    // Font store access strobes
    typedef struct packed {
        logic wen_width;
        logic ren_width;
        logic wen_col;
        logic ren_col;
    } font_ctl_t;

    // Clamp a widened coordinate sum to the screen coordinate range
    function automatic coord_t sat_coord(input logic [13:0] v);
        coord_t r;
        if (v > 14'(COORD_MAX))
            r = COORD_MAX;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

### rtl/gtr_font.sv
// Font store: glyph width table with per-entry valid bits and glyph column memory.
// Depends on gtr_pkg for the access strobe struct.
`timescale 1ns / 1ps

module gtr_font #(
    parameter int NUM_CODES       = 256,
    parameter int MAX_GLYPH_WIDTH = 32,
    localparam int CODE_W = $clog2(NUM_CODES),
    localparam int WID_W  = $clog2(MAX_GLYPH_WIDTH + 1),
    localparam int CA_W   = $clog2(NUM_CODES * MAX_GLYPH_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gtr_pkg::font_ctl_t ctl,
    input  logic [CODE_W-1:0] width_addr,
    input  logic [WID_W-1:0]  width_wdata,
    output logic [WID_W-1:0]  width_rdata,
    input  logic [CA_W-1:0]   col_addr,
    input  logic [15:0]       col_wdata,
    output logic [15:0]       col_rdata
);

    localparam int COL_DEPTH = NUM_CODES * MAX_GLYPH_WIDTH;

    logic [WID_W-1:0] width_mem [NUM_CODES];
    logic [15:0]      col_mem   [COL_DEPTH];

    logic [NUM_CODES-1:0] valid_reg;
    logic                 valid_rd_reg;
    logic [WID_W-1:0]     width_rd_reg;
    logic [15:0]          col_rd_reg;

    // Valid bits: an entry never written reads as absent (width zero)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wen_width)
                valid_reg[width_addr] <= 1'b1;
            if (ctl.ren_width)
                valid_rd_reg <= valid_reg[width_addr];
        end
    end

    // Width table, one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wen_width)
            width_mem[width_addr] <= width_wdata;
        if (ctl.ren_width)
            width_rd_reg <= width_mem[width_addr];
    end

    // Column memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wen_col)
            col_mem[col_addr] <= col_wdata;
        if (ctl.ren_col)
            col_rd_reg <= col_mem[col_addr];
    end

    assign width_rdata = valid_rd_reg ? width_rd_reg : '0;
    assign col_rdata   = col_rd_reg;

endmodule

### rtl/glyph_text_renderer_core.sv
// Glyph text renderer core. Loads and home are done at the edge that accepts them and
// never raise busy; a draw of an absent glyph keeps busy high for 1 cycle. A draw of a
// glyph w columns wide holds busy high through ST_WRAP, ST_MASK and ST_EMIT; column
// items, registered from ST_EMIT, follow one item per cycle, paced by the single read port
// of the glyph column memory. The receiver cannot stall. Reset (rst_n low, asynchronous)
// clears all widths, loads the register defaults and homes the cursor; no clearing pass.
`timescale 1ns / 1ps

module glyph_text_renderer_core #(
    parameter int GLYPH_HEIGHT    = 16,
    parameter int MAX_GLYPH_WIDTH = 32,
    parameter int NUM_CODES       = 256,
    localparam int CODE_W = $clog2(NUM_CODES),
    localparam int WID_W  = $clog2(MAX_GLYPH_WIDTH + 1),
    localparam int CA_W   = $clog2(NUM_CODES * MAX_GLYPH_WIDTH)
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [4:0]  column_index,
    input  logic [15:0] load_value,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    // result channel
    output logic        strobe,
    output logic [11:0] pix_x,
    output logic [11:0] pix_y,
    output logic [15:0] ink,
    output logic [15:0] write_mask,
    output logic        last
);

    localparam int ROW_BITS = (GLYPH_HEIGHT < 16) ? GLYPH_HEIGHT : 16;
    localparam logic [15:0] ROW_MASK = 16'((32'd1 << ROW_BITS) - 32'd1);

    // Configuration registers
    gtr_pkg::coord_t screen_width_reg, screen_height_reg;
    gtr_pkg::coord_t left_margin_reg, top_margin_reg;
    logic [7:0]      line_step_reg, char_gap_reg;

    // Sequencer and draw context
    gtr_pkg::state_t   state_reg, state_next;
    gtr_pkg::coord_t   cursor_x_reg, cursor_x_next;
    gtr_pkg::coord_t   cursor_y_reg, cursor_y_next;
    logic [CODE_W-1:0] code_reg;
    logic              code_ok_reg;
    logic [WID_W-1:0]  w_reg, w_next;
    logic [WID_W-1:0]  j_reg, j_next;
    logic [15:0]       ymask_reg, ymask_next;

    // Result registers
    logic              strobe_reg, strobe_next;
    gtr_pkg::coord_t   pix_x_reg, pix_x_next;
    gtr_pkg::coord_t   pix_y_reg;
    logic [15:0]       ink_reg, mask_reg, mask_next;
    logic              last_reg;

    // Font interface
    gtr_pkg::font_ctl_t font_ctl;
    logic [WID_W-1:0]   width_wdata, width_rdata;
    logic [CA_W-1:0]    col_addr;
    logic [15:0]        col_rdata;

    logic              accept;
    logic              code_ok;
    logic              col_ok;
    logic              last_col;
    logic              glyph_skip;
    logic              wrap;
    logic [CA_W-1:0]   wr_base, rd_base;
    logic [WID_W-1:0]  rd_col;
    logic [12:0]       x_sum;

    assign busy    = (state_reg != gtr_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign code_ok = ({1'b0, char_code} < 9'(NUM_CODES));
    assign col_ok  = ({1'b0, column_index} < 6'(MAX_GLYPH_WIDTH));

    assign last_col   = (({1'b0, j_reg} + 1'b1) == {1'b0, w_reg});
    assign glyph_skip = !code_ok_reg || (width_rdata == '0);
    assign wrap       = (({1'b0, cursor_x_reg} + 13'(width_rdata)) >= {1'b0, screen_width_reg});
    assign x_sum      = {1'b0, cursor_x_reg} + 13'(j_reg);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gtr_pkg::ST_IDLE:
            begin
                if (accept && (cmd == gtr_pkg::CMD_DRAW))
                    state_next = gtr_pkg::ST_WRAP;
            end
            gtr_pkg::ST_WRAP:
            begin
                if (glyph_skip)
                    state_next = gtr_pkg::ST_IDLE;
                else
                    state_next = gtr_pkg::ST_MASK;
            end
            gtr_pkg::ST_MASK:
            begin
                state_next = gtr_pkg::ST_EMIT;
            end
            gtr_pkg::ST_EMIT:
            begin
                if (last_col)
                    state_next = gtr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gtr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: font strobes and the column being fetched
    always_comb
    begin
        font_ctl = '0;
        rd_col   = '0;
        case (state_reg)
            gtr_pkg::ST_IDLE:
            begin
                font_ctl.wen_width = accept && (cmd == gtr_pkg::CMD_SET_WIDTH) && code_ok;
                font_ctl.ren_width = accept && (cmd == gtr_pkg::CMD_DRAW);
                font_ctl.wen_col   = accept && (cmd == gtr_pkg::CMD_WRITE_COL)
                                     && code_ok && col_ok;
            end
            gtr_pkg::ST_MASK:
            begin
                font_ctl.ren_col = 1'b1;
            end
            gtr_pkg::ST_EMIT:
            begin
                font_ctl.ren_col = !last_col;
                rd_col           = j_reg + 1'b1;
            end
            default:
            begin
                font_ctl = '0;
            end
        endcase
    end

    // Font addressing and load data
    assign wr_base     = CA_W'(char_code[CODE_W-1:0]) * CA_W'(MAX_GLYPH_WIDTH);
    assign rd_base     = CA_W'(code_reg) * CA_W'(MAX_GLYPH_WIDTH);
    assign col_addr    = busy ? (rd_base + CA_W'(rd_col)) : (wr_base + CA_W'(column_index));
    assign width_wdata = (load_value > 16'(MAX_GLYPH_WIDTH))
                         ? WID_W'(MAX_GLYPH_WIDTH) : load_value[WID_W-1:0];

    gtr_font #(
        .NUM_CODES       (NUM_CODES),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_font (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (font_ctl),
        .width_addr  (char_code[CODE_W-1:0]),
        .width_wdata (width_wdata),
        .width_rdata (width_rdata),
        .col_addr    (col_addr),
        .col_wdata   (load_value & ROW_MASK),
        .col_rdata   (col_rdata)
    );

    // Cursor, draw context and result datapath
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        w_next        = w_reg;
        j_next        = j_reg;
        ymask_next    = ymask_reg;
        strobe_next   = 1'b0;
        pix_x_next    = gtr_pkg::sat_coord({1'b0, x_sum});
        mask_next     = (x_sum < {1'b0, screen_width_reg}) ? ymask_reg : 16'h0000;

        case (state_reg)
            gtr_pkg::ST_IDLE:
            begin
                if (accept && (cmd == gtr_pkg::CMD_HOME))
                begin
                    cursor_x_next = left_margin_reg;
                    cursor_y_next = top_margin_reg;
                end
            end
            gtr_pkg::ST_WRAP:
            begin
                w_next = width_rdata;
                if (!glyph_skip && wrap)
                begin
                    cursor_x_next = left_margin_reg;
                    cursor_y_next = gtr_pkg::sat_coord({2'b00, cursor_y_reg}
                                                       + 14'(line_step_reg));
                end
            end
            gtr_pkg::ST_MASK:
            begin
                // rows on screen, from the settled cursor line
                for (int i = 0; i < 16; i++)
                begin
                    ymask_next[i] = (i < ROW_BITS)
                                    && (({1'b0, cursor_y_reg} + 13'(i))
                                        < {1'b0, screen_height_reg});
                end
                j_next = '0;
            end
            gtr_pkg::ST_EMIT:
            begin
                strobe_next = 1'b1;
                j_next      = j_reg + 1'b1;
                if (last_col)
                begin
                    cursor_x_next = gtr_pkg::sat_coord({2'b00, cursor_x_reg}
                                                       + 14'(w_reg) + 14'(char_gap_reg));
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gtr_pkg::ST_IDLE;
            cursor_x_reg <= gtr_pkg::LEFT_MARGIN_RST;
            cursor_y_reg <= gtr_pkg::TOP_MARGIN_RST;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= gtr_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= gtr_pkg::SCREEN_HEIGHT_RST;
            left_margin_reg   <= gtr_pkg::LEFT_MARGIN_RST;
            top_margin_reg    <= gtr_pkg::TOP_MARGIN_RST;
            line_step_reg     <= gtr_pkg::LINE_STEP_RST;
            char_gap_reg      <= gtr_pkg::CHAR_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gtr_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                gtr_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                gtr_pkg::REG_LEFT_MARGIN:   left_margin_reg   <= cfg_wdata;
                gtr_pkg::REG_TOP_MARGIN:    top_margin_reg    <= cfg_wdata;
                gtr_pkg::REG_LINE_STEP:     line_step_reg     <= cfg_wdata[7:0];
                gtr_pkg::REG_CHAR_GAP:      char_gap_reg      <= cfg_wdata[7:0];
                default:                    ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg    <= char_code[CODE_W-1:0];
            code_ok_reg <= code_ok;
        end
        w_reg     <= w_next;
        j_reg     <= j_next;
        ymask_reg <= ymask_next;
        if (state_reg == gtr_pkg::ST_EMIT)
        begin
            pix_x_reg <= pix_x_next;
            pix_y_reg <= cursor_y_reg;
            ink_reg   <= col_rdata;
            mask_reg  <= mask_next;
            last_reg  <= last_col;
        end
    end

    assign strobe     = strobe_reg;
    assign pix_x      = pix_x_reg;
    assign pix_y      = pix_y_reg;
    assign ink        = ink_reg;
    assign write_mask = mask_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // A result item only ever follows a column emit cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == gtr_pkg::ST_EMIT))
        else $error("result strobe without a column emit");

    // The final column of a glyph ends the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result strobe after the final column");

    // Nothing is emitted in the cycle after the block was idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !strobe)
        else $error("result strobe while idle");

    // The column counter stays inside the glyph while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtr_pkg::ST_EMIT) |-> (j_reg < w_reg))
        else $error("column counter beyond glyph width");
`endif

endmodule

### tb/sv/tb_glyph_text_renderer_core.sv
// Self-checking testbench for glyph_text_renderer_core: font loads, draws, wraps and clipping.
// A scoreboard class predicts every emitted pixel column; plain tasks drive the block.
// Depends on rtl/gtr_pkg.sv and rtl/glyph_text_renderer_core.sv.
`timescale 1ns / 1ps

module tb_glyph_text_renderer_core;

    localparam int GLYPH_H        = 16;
    localparam int MAX_W          = 32;
    localparam int CODES          = 256;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int ITEMS_PER_PHASE = 90;

    // One emitted glyph column
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] ink;
        logic [15:0] mask;
        logic        last;
    } pixel_column_t;

    // Font, cursor and register copy; predicts columns and checks them in order
    class render_scoreboard;
        bit [11:0] scr_w, scr_h, lmargin, tmargin;
        bit [7:0]  lstep, gap;
        bit [5:0]  widths [CODES];
        bit [15:0] columns [CODES][MAX_W];
        bit [31:0] written [CODES];
        bit [11:0] cur_x, cur_y;
        pixel_column_t expected_columns [$];
        int errors;

        function new();
            scr_w   = gtr_pkg::SCREEN_WIDTH_RST;
            scr_h   = gtr_pkg::SCREEN_HEIGHT_RST;
            lmargin = gtr_pkg::LEFT_MARGIN_RST;
            tmargin = gtr_pkg::TOP_MARGIN_RST;
            lstep   = gtr_pkg::LINE_STEP_RST;
            gap     = gtr_pkg::CHAR_GAP_RST;
            cur_x   = gtr_pkg::LEFT_MARGIN_RST;
            cur_y   = gtr_pkg::TOP_MARGIN_RST;
            errors  = 0;
        endfunction

        function bit [11:0] clamp(int v);
            return (v > int'(gtr_pkg::COORD_MAX)) ? gtr_pkg::COORD_MAX : v[11:0];
        endfunction

        function void set_reg(gtr_pkg::cfg_idx_t idx, bit [11:0] data);
            case (idx)
                gtr_pkg::REG_SCREEN_WIDTH:  scr_w   = data;
                gtr_pkg::REG_SCREEN_HEIGHT: scr_h   = data;
                gtr_pkg::REG_LEFT_MARGIN:   lmargin = data;
                gtr_pkg::REG_TOP_MARGIN:    tmargin = data;
                gtr_pkg::REG_LINE_STEP:     lstep   = data[7:0];
                gtr_pkg::REG_CHAR_GAP:      gap     = data[7:0];
                default: ;
            endcase
        endfunction

        // True when every column the glyph would read has been loaded
        function bit can_draw(int code);
            bit [31:0] need;
            need = (widths[code] >= MAX_W) ? '1 : (32'd1 << widths[code]) - 32'd1;
            return (written[code] & need) == need;
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        // Cursor wrap, row mask and one column per glyph column
        function void draw_glyph(int code);
            int w;
            int x;
            bit [15:0] ymask;
            pixel_column_t pc;
            w = widths[code];
            if (w == 0)
                return;
            if (int'(cur_x) + w >= int'(scr_w)) begin
                cur_x = lmargin;
                cur_y = clamp(int'(cur_y) + int'(lstep));
            end
            ymask = '0;
            for (int i = 0; i < GLYPH_H && i < 16; i++)
                if (int'(cur_y) + i < int'(scr_h))
                    ymask[i] = 1'b1;
            for (int j = 0; j < w && j < MAX_W; j++) begin
                x = int'(cur_x) + j;
                pc.x    = clamp(x);
                pc.y    = cur_y;
                pc.ink  = columns[code][j];
                pc.mask = (x < int'(scr_w)) ? ymask : 16'h0000;
                pc.last = (j + 1 == w);
                expected_columns.push_back(pc);
            end
            cur_x = clamp(int'(cur_x) + w + int'(gap));
        endfunction

        function void note_item(gtr_pkg::cmd_t op, bit [7:0] code, bit [4:0] col,
                                bit [15:0] val);
            case (op)
                gtr_pkg::CMD_SET_WIDTH: widths[code] = (val > MAX_W) ? 6'(MAX_W) : val[5:0];
                gtr_pkg::CMD_WRITE_COL:
                begin
                    if (col < MAX_W) begin
                        columns[code][col] = val;
                        written[code][col] = 1'b1;
                    end
                end
                gtr_pkg::CMD_DRAW: draw_glyph(code);
                gtr_pkg::CMD_HOME:
                begin
                    cur_x = lmargin;
                    cur_y = tmargin;
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_column(bit [11:0] x, bit [11:0] y, bit [15:0] ink,
                                   bit [15:0] mask, bit last);
            pixel_column_t pc;
            if (expected_columns.size() == 0) begin
                $display("%0t: unexpected column: expected none, actual x=%0d y=%0d ink=0x%0h",
                         $time, x, y, ink);
                errors++;
                return;
            end
            pc = expected_columns.pop_front();
            check_field("pix_x", pc.x, x);
            check_field("pix_y", pc.y, y);
            check_field("ink", pc.ink, ink);
            check_field("write_mask", pc.mask, mask);
            check_field("last", pc.last, last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [4:0]  column_index;
    logic [15:0] load_value;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [11:0] cfg_wdata;
    logic        strobe;
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic [15:0] ink;
    logic [15:0] write_mask;
    logic        last;

    render_scoreboard sb;
    int idle_pct;
    int items_sent;
    int quiet_cycles;

    glyph_text_renderer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .char_code    (char_code),
        .column_index (column_index),
        .load_value   (load_value),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .strobe       (strobe),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .ink          (ink),
        .write_mask   (write_mask),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_column(pix_x, pix_y, ink, write_mask, last);
    end

    // Watchdog: cycles with neither an accepted item nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_glyph_text_renderer_core: FAIL");
            $finish;
        end
    end

    // Present one item, with an optional gap before it; returns at a falling edge
    task automatic send_item(gtr_pkg::cmd_t op, bit [7:0] code, bit [4:0] col,
                             bit [15:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start        = 1'b1;
        cmd          = op;
        char_code    = code;
        column_index = col;
        load_value   = val;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(op, code, col, val);
        items_sent++;
        @(negedge clk);
    endtask

    // Drain all expected columns, then let the block fall quiet
    task automatic settle();
        start = 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(gtr_pkg::cfg_idx_t idx, bit [11:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(bit [11:0] w, bit [11:0] h, bit [11:0] lm, bit [11:0] tm,
                             bit [11:0] ls, bit [11:0] gp);
        settle();
        write_reg(gtr_pkg::REG_SCREEN_WIDTH, w);
        write_reg(gtr_pkg::REG_SCREEN_HEIGHT, h);
        write_reg(gtr_pkg::REG_LEFT_MARGIN, lm);
        write_reg(gtr_pkg::REG_TOP_MARGIN, tm);
        write_reg(gtr_pkg::REG_LINE_STEP, ls);
        write_reg(gtr_pkg::REG_CHAR_GAP, gp);
        cfg_we = 1'b0;
    endtask

    // Loaded glyph at random, now and then an absent one; -1 when none is ready
    function automatic int pick_draw_code();
        int ready [$];
        int c;
        if ($urandom_range(9) == 0) begin
            for (int t = 0; t < 8; t++) begin
                c = $urandom_range(CODES - 1);
                if (sb.widths[c] == 0)
                    return c;
            end
        end
        for (int k = 0; k < CODES; k++)
            if (sb.widths[k] != 0 && sb.can_draw(k))
                ready.push_back(k);
        if (ready.size() == 0)
            return -1;
        return ready[$urandom_range(ready.size() - 1)];
    endfunction

    // Width then every column of one glyph, mostly narrow
    task automatic define_glyph();
        int code;
        int r;
        int val;
        int n;
        code = $urandom_range(CODES - 1);
        r = $urandom_range(9);
        if (r < 7)
            val = $urandom_range(1, 8);
        else if (r < 9)
            val = $urandom_range(9, MAX_W);
        else
            val = $urandom_range(65535);
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'(code), 5'($urandom_range(31)), 16'(val));
        n = (val > MAX_W) ? MAX_W : val;
        for (int j = 0; j < n; j++)
            send_item(gtr_pkg::CMD_WRITE_COL, 8'(code), 5'(j), 16'($urandom_range(65535)));
    endtask

    task automatic draw_run();
        int c;
        repeat ($urandom_range(1, 6)) begin
            c = pick_draw_code();
            if (c < 0)
                send_item(gtr_pkg::CMD_HOME, 8'($urandom_range(255)), 5'($urandom_range(31)),
                          16'($urandom_range(65535)));
            else
                send_item(gtr_pkg::CMD_DRAW, 8'(c), 5'($urandom_range(31)),
                          16'($urandom_range(65535)));
        end
    endtask

    task automatic run_random(int n_items);
        int stop;
        int r;
        stop = items_sent + n_items;
        send_item(gtr_pkg::CMD_HOME, 8'($urandom_range(255)), 5'($urandom_range(31)),
                  16'($urandom_range(65535)));
        while (items_sent < stop) begin
            r = $urandom_range(99);
            if (r < 30)
                define_glyph();
            else if (r < 82)
                draw_run();
            else if (r < 90)
                send_item(gtr_pkg::CMD_HOME, 8'($urandom_range(255)), 5'($urandom_range(31)),
                          16'($urandom_range(65535)));
            else if (r < 95)
                // stray column load, may leave a glyph partly loaded
                send_item(gtr_pkg::CMD_WRITE_COL, 8'($urandom_range(255)),
                          5'($urandom_range(31)), 16'($urandom_range(65535)));
            else
                // stray width change, may make a glyph absent or not yet drawable
                send_item(gtr_pkg::CMD_SET_WIDTH, 8'($urandom_range(255)),
                          5'($urandom_range(31)), 16'($urandom_range(40)));
        end
    endtask

    // Hand-picked items at the reset settings
    task automatic run_directed();
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'h41, 5'd0, 16'd3);
        send_item(gtr_pkg::CMD_WRITE_COL, 8'h41, 5'd0, 16'hFFFF);
        send_item(gtr_pkg::CMD_WRITE_COL, 8'h41, 5'd1, 16'h0000);
        send_item(gtr_pkg::CMD_WRITE_COL, 8'h41, 5'd2, 16'hA5A5);
        send_item(gtr_pkg::CMD_DRAW, 8'h41, 5'd31, 16'hFFFF);
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'hFF, 5'd31, 16'd1);
        send_item(gtr_pkg::CMD_WRITE_COL, 8'hFF, 5'd0, 16'h8001);
        send_item(gtr_pkg::CMD_DRAW, 8'hFF, 5'd0, 16'h0000);
        // absent glyph: nothing emitted, cursor unchanged
        send_item(gtr_pkg::CMD_DRAW, 8'h00, 5'd0, 16'h0000);
        // oversized width saturates; top column index
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'h01, 5'd0, 16'hFFFF);
        send_item(gtr_pkg::CMD_WRITE_COL, 8'h01, 5'd31, 16'h5A5A);
        send_item(gtr_pkg::CMD_HOME, 8'h00, 5'd0, 16'h0000);
        send_item(gtr_pkg::CMD_DRAW, 8'h41, 5'd0, 16'h0000);
        // glyph made absent, then restored
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'h41, 5'd0, 16'd0);
        send_item(gtr_pkg::CMD_DRAW, 8'h41, 5'd0, 16'h0000);
        send_item(gtr_pkg::CMD_SET_WIDTH, 8'h41, 5'd0, 16'd3);
        send_item(gtr_pkg::CMD_DRAW, 8'h41, 5'd0, 16'h0000);
        send_item(gtr_pkg::CMD_DRAW, 8'hFF, 5'd0, 16'h0000);
    endtask

    initial
    begin
        sb           = new();
        idle_pct     = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = gtr_pkg::CMD_SET_WIDTH;
        char_code    = '0;
        column_index = '0;
        load_value   = '0;
        cfg_we       = 1'b0;
        cfg_addr     = gtr_pkg::REG_SCREEN_WIDTH;
        cfg_wdata    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // widest screen, zero margins, largest steps; no idling
        configure(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd255, 12'd255);
        idle_pct = 0;
        run_random(ITEMS_PER_PHASE);

        // one-pixel screen, margins at the far corner: every draw wraps and saturates
        configure(12'd1, 12'd1, 12'd4095, 12'd4095, 12'd255, 12'd0);
        idle_pct = 71;
        run_random(ITEMS_PER_PHASE);

        // small screen with partial row masks, no line step
        configure(12'd40, 12'd20, 12'd3, 12'd8, 12'd0, 12'd1);
        idle_pct = 15;
        run_random(ITEMS_PER_PHASE);

        // modest random screen, margin may lie past the right edge
        configure(12'($urandom_range(20, 300)), 12'($urandom_range(1, 40)),
                  12'($urandom_range(300)), 12'($urandom_range(30)),
                  12'($urandom_range(4095)), 12'($urandom_range(8)));
        idle_pct = 71;
        run_random(ITEMS_PER_PHASE);

        // fully random registers
        configure(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                  12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  12'($urandom_range(4095)), 12'($urandom_range(4095)));
        idle_pct = 15;
        run_random(ITEMS_PER_PHASE);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_glyph_text_renderer_core: PASS");
        else
            $display("tb_glyph_text_renderer_core: FAIL");
        $finish;
    end

endmodule
